// ===== hdl/wfrm_pkg.sv =====
// ----------------------------------------------------------------------------
// wfrm_pkg
// Shared constants and types for the windowed frame-rate meter.
// ----------------------------------------------------------------------------
package wfrm_pkg;

  // Window length (frame times averaged) and derived widths
  localparam int WINDOW      = 16;
  localparam int TS_W        = 32;
  localparam int IDX_W       = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W       = $clog2(WINDOW + 1);
  localparam int SUM_W       = TS_W + $clog2(WINDOW + 1);
  localparam int BIT_W       = $clog2(SUM_W);

  // Rate arithmetic: fps = 1000 * count * 2^16 / sum
  localparam int MS_PER_SEC  = 1000;
  localparam int Q_FRAC      = 16;
  localparam int NUM_W       = $clog2(MS_PER_SEC * WINDOW + 1) + Q_FRAC;
  localparam int STEP_W      = $clog2(NUM_W);
  localparam int FPS_W       = 32;
  localparam int QX_W        = (NUM_W > FPS_W) ? NUM_W : FPS_W + 1;

  // Accumulator status toward the sequencer
  typedef struct packed {
    logic               done;
    logic [SUM_W-1:0]   sum;
    logic [CNT_W-1:0]   count;
  } acc_res_t;

  // Divider status toward the sequencer
  typedef struct packed {
    logic               done;
    logic               sat;
    logic [FPS_W-1:0]   fps;
  } div_res_t;

endpackage

// ===== hdl/wfrm_accum.sv =====
// ----------------------------------------------------------------------------
// wfrm_accum
// Frame-time ring and bit-serial update of the delta and the window sum.
// ----------------------------------------------------------------------------
module wfrm_accum
  import wfrm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [TS_W-1:0]   timestamp,
  input  logic              cfg_we,
  input  logic [TS_W-1:0]   cfg_wdata,
  output acc_res_t          res
);

  typedef enum logic [2:0] {
    A_IDLE  = 3'b001,
    A_LOAD  = 3'b010,
    A_SHIFT = 3'b100
  } acc_state_t;

  acc_state_t          state_r, state_nxt;

  logic [TS_W-1:0]     ring [WINDOW];
  logic [TS_W-1:0]     rd_data_r;
  logic                ring_we;

  logic [TS_W-1:0]     last_ts_r, last_ts_nxt;
  logic [TS_W-1:0]     ts_sh_r, ts_sh_nxt;
  logic [TS_W-1:0]     old_sh_r, old_sh_nxt;
  logic [TS_W-1:0]     delta_sh_r, delta_sh_nxt;
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic [IDX_W-1:0]    wr_pos_r, wr_pos_nxt;
  logic [CNT_W-1:0]    fill_r, fill_nxt;
  logic [BIT_W-1:0]    bit_r, bit_nxt;
  logic                bw1_r, bw1_nxt;
  logic                c1_r, c1_nxt;
  logic                bw2_r, bw2_nxt;
  logic                done_r, done_nxt;

  logic                full;
  logic                in_ts;
  logic                a_bit, b_bit, d_bit, s1_bit, o_bit, s2_bit;

  assign full  = (fill_r == CNT_W'(WINDOW));
  assign in_ts = (bit_r < BIT_W'(TS_W));

  // Per-bit arithmetic: delta = now - last, sum = sum + delta - old
  always_comb begin
    a_bit   = ts_sh_r[0];
    b_bit   = last_ts_r[0];
    d_bit   = in_ts & (a_bit ^ b_bit ^ bw1_r);
    bw1_nxt = (~a_bit & b_bit) | (~(a_bit ^ b_bit) & bw1_r);
    s1_bit  = sum_r[0] ^ d_bit ^ c1_r;
    c1_nxt  = (sum_r[0] & d_bit) | (sum_r[0] & c1_r) | (d_bit & c1_r);
    o_bit   = old_sh_r[0];
    s2_bit  = s1_bit ^ o_bit ^ bw2_r;
    bw2_nxt = (~s1_bit & o_bit) | (~(s1_bit ^ o_bit) & bw2_r);
  end

  // Sequencing and next-state values
  always_comb begin
    state_nxt    = state_r;
    last_ts_nxt  = last_ts_r;
    ts_sh_nxt    = ts_sh_r;
    old_sh_nxt   = old_sh_r;
    delta_sh_nxt = delta_sh_r;
    sum_nxt      = sum_r;
    wr_pos_nxt   = wr_pos_r;
    fill_nxt     = fill_r;
    bit_nxt      = bit_r;
    done_nxt     = 1'b0;
    ring_we      = 1'b0;
    case (state_r)
      A_IDLE: begin
        if (cfg_we) begin
          last_ts_nxt = cfg_wdata;
        end
        if (start) begin
          ts_sh_nxt = timestamp;
          state_nxt = A_LOAD;
        end
      end
      A_LOAD: begin
        // slot being overwritten leaves the sum only once the window is full
        old_sh_nxt = full ? rd_data_r : '0;
        bit_nxt    = '0;
        state_nxt  = A_SHIFT;
      end
      A_SHIFT: begin
        sum_nxt    = {s2_bit, sum_r[SUM_W-1:1]};
        old_sh_nxt = {1'b0, old_sh_r[TS_W-1:1]};
        if (in_ts) begin
          ts_sh_nxt    = {1'b0, ts_sh_r[TS_W-1:1]};
          last_ts_nxt  = {ts_sh_r[0], last_ts_r[TS_W-1:1]};
          delta_sh_nxt = {d_bit, delta_sh_r[TS_W-1:1]};
        end
        bit_nxt = bit_r + BIT_W'(1);
        if (bit_r == BIT_W'(SUM_W - 1)) begin
          ring_we    = 1'b1;
          wr_pos_nxt = (wr_pos_r == IDX_W'(WINDOW - 1)) ? '0 : wr_pos_r + IDX_W'(1);
          fill_nxt   = full ? fill_r : fill_r + CNT_W'(1);
          done_nxt   = 1'b1;
          state_nxt  = A_IDLE;
        end
      end
      default: state_nxt = A_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= A_IDLE;
      last_ts_r <= '0;
      sum_r     <= '0;
      wr_pos_r  <= '0;
      fill_r    <= '0;
      done_r    <= 1'b0;
      bw1_r     <= 1'b0;
      c1_r      <= 1'b0;
      bw2_r     <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      last_ts_r <= last_ts_nxt;
      sum_r     <= sum_nxt;
      wr_pos_r  <= wr_pos_nxt;
      fill_r    <= fill_nxt;
      done_r    <= done_nxt;
      if (state_r == A_SHIFT) begin
        bw1_r <= bw1_nxt;
        c1_r  <= c1_nxt;
        bw2_r <= bw2_nxt;
      end else begin
        bw1_r <= 1'b0;
        c1_r  <= 1'b0;
        bw2_r <= 1'b0;
      end
    end
  end

  // Shift registers (payload, no reset)
  always_ff @(posedge clk) begin
    ts_sh_r    <= ts_sh_nxt;
    old_sh_r   <= old_sh_nxt;
    delta_sh_r <= delta_sh_nxt;
    bit_r      <= bit_nxt;
  end

  // Ring memory: one registered read at transfer, one write at pass end
  always_ff @(posedge clk) begin
    if (start && (state_r == A_IDLE)) begin
      rd_data_r <= ring[wr_pos_r];
    end
    if (ring_we) begin
      ring[wr_pos_r] <= delta_sh_r;
    end
  end

  assign res.done  = done_r;
  assign res.sum   = sum_r;
  assign res.count = fill_r;

endmodule

// ===== hdl/wfrm_div.sv =====
// ----------------------------------------------------------------------------
// wfrm_div
// Restoring divider, one quotient bit per cycle, with Q16.16 saturation.
// ----------------------------------------------------------------------------
module wfrm_div
  import wfrm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [CNT_W-1:0]  count,
  input  logic [SUM_W-1:0]  divisor,
  output div_res_t          res
);

  typedef enum logic [1:0] {
    D_IDLE = 2'b01,
    D_RUN  = 2'b10
  } div_state_t;

  div_state_t          state_r;
  logic [NUM_W-1:0]    num_sh_r;
  logic [NUM_W-1:0]    quo_r;
  logic [SUM_W-1:0]    div_r;
  logic [SUM_W-1:0]    rem_r;
  logic [STEP_W-1:0]   step_r;
  logic                zero_r;
  logic                done_r;
  logic                sat_r;
  logic [FPS_W-1:0]    fps_r;

  logic [NUM_W-1:0]    numer;
  logic [SUM_W:0]      trial;
  logic [SUM_W:0]      diff;
  logic                qbit;
  logic [SUM_W-1:0]    rem_nxt;
  logic [NUM_W-1:0]    quo_nxt;
  logic [QX_W-1:0]     quo_ext;
  logic                ovf;

  // Numerator 1000 * count, scaled to Q16.16
  assign numer = (NUM_W'(count) * NUM_W'(MS_PER_SEC)) << Q_FRAC;

  // One restoring step
  always_comb begin
    trial   = {rem_r, num_sh_r[NUM_W-1]};
    diff    = trial - {1'b0, div_r};
    qbit    = ~diff[SUM_W];
    rem_nxt = qbit ? diff[SUM_W-1:0] : trial[SUM_W-1:0];
    quo_nxt = {quo_r[NUM_W-2:0], qbit};
    quo_ext = QX_W'(quo_nxt);
    ovf     = |quo_ext[QX_W-1:FPS_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        D_IDLE: begin
          if (start) begin
            state_r <= D_RUN;
          end
        end
        D_RUN: begin
          if (step_r == STEP_W'(NUM_W - 1)) begin
            done_r  <= 1'b1;
            state_r <= D_IDLE;
          end
        end
        default: state_r <= D_IDLE;
      endcase
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (state_r == D_IDLE) begin
      if (start) begin
        num_sh_r <= numer;
        div_r    <= divisor;
        zero_r   <= (divisor == '0);
        rem_r    <= '0;
        quo_r    <= '0;
        step_r   <= '0;
      end
    end else begin
      num_sh_r <= {num_sh_r[NUM_W-2:0], 1'b0};
      rem_r    <= rem_nxt;
      quo_r    <= quo_nxt;
      step_r   <= step_r + STEP_W'(1);
      if (step_r == STEP_W'(NUM_W - 1)) begin
        // empty window sum or too-large rate pins to full scale
        sat_r <= zero_r | ovf;
        fps_r <= (zero_r | ovf) ? '1 : quo_ext[FPS_W-1:0];
      end
    end
  end

  assign res.done = done_r;
  assign res.sat  = sat_r;
  assign res.fps  = fps_r;

endmodule

// ===== hdl/windowed_frame_rate_meter_top.sv =====
// ----------------------------------------------------------------------------
// windowed_frame_rate_meter_top
// Moving-average frame-rate meter: timestamps in, Q16.16 frames/second out.
// ----------------------------------------------------------------------------
// Each transfer on the input channel is a millisecond frame-end timestamp and
// produces exactly one result: 1000 * count / sum in unsigned Q16.16, where
// sum covers the last WINDOW frame times (count of them, up to WINDOW). The
// result reads 0xFFFFFFFF with out_saturated set when the window sum is zero
// or the rate overflows. One timestamp is handled at a time; each item goes
// from transfer to result through the bit-serial pass that forms the delta
// and updates the 37-bit window sum, followed by the divider that yields one
// quotient bit per cycle. A finished result sits in the output register, so
// the next timestamp is taken while it waits. Writing cfg_wdata through
// cfg_we loads the previous-frame timestamp.
// ----------------------------------------------------------------------------
module windowed_frame_rate_meter_top
  import wfrm_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [TS_W-1:0]    in_frame_timestamp,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [FPS_W-1:0]   out_fps_value,
  output logic               out_saturated,
  input  logic               cfg_we,
  input  logic [TS_W-1:0]    cfg_wdata
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_ACC  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_WAIT = 4'b1000
  } top_state_t;

  top_state_t          state_r, state_nxt;
  acc_res_t            acc_res;
  div_res_t            div_res;
  logic                acc_start;
  logic                div_start;
  logic                res_ready;
  logic                out_load;
  logic                out_valid_r, out_valid_nxt;
  logic [FPS_W-1:0]    out_fps_r;
  logic                out_sat_r;

  assign in_ready  = (state_r == ST_IDLE);
  assign acc_start = in_valid && in_ready;
  assign div_start = (state_r == ST_ACC) && acc_res.done;
  assign res_ready = ((state_r == ST_DIV) && div_res.done) || (state_r == ST_WAIT);
  assign out_load  = res_ready && (!out_valid_r || out_ready);

  // Item sequencing
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (acc_start)      state_nxt = ST_ACC;
      ST_ACC:  if (acc_res.done)   state_nxt = ST_DIV;
      ST_DIV: begin
        if (div_res.done) begin
          state_nxt = out_load ? ST_IDLE : ST_WAIT;
        end
      end
      ST_WAIT: if (out_load)       state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Output register valid: set on load, cleared on transfer
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_fps_r <= div_res.fps;
      out_sat_r <= div_res.sat;
    end
  end

  wfrm_accum u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (acc_start),
    .timestamp (in_frame_timestamp),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .res       (acc_res)
  );

  wfrm_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .count   (acc_res.count),
    .divisor (acc_res.sum),
    .res     (div_res)
  );

  assign out_valid     = out_valid_r;
  assign out_fps_value = out_fps_r;
  assign out_saturated = out_sat_r;

endmodule

// ===== hdl/wfrm_checker.sv =====
// ----------------------------------------------------------------------------
// wfrm_port_checks
// Port-level checks for the frame-rate meter, bound to the top level.
// ----------------------------------------------------------------------------
module wfrm_port_checks
  import wfrm_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [FPS_W-1:0]   out_fps_value,
  input logic               out_saturated
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_fps_value)
      && $stable(out_saturated))
    else $error("result changed while stalled");

  // One item in work at a time: the input stays busy after a transfer
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready ##1 !in_ready)
    else $error("input taken while busy");

  // Saturation pins the value to full scale
  a_sat_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |-> out_fps_value == '1)
    else $error("saturated result not full scale");

  // No result straight out of reset
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind windowed_frame_rate_meter_top wfrm_port_checks u_wfrm_port_checks (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_fps_value (out_fps_value),
  .out_saturated (out_saturated)
);

// ===== tb/wfrm_checker.sv =====
// ----------------------------------------------------------------------------
// wfrm_checker
// Watches the frame-rate meter's ports, predicts each rate and compares it.
// ----------------------------------------------------------------------------
// The checker follows start-time loads and accepted timestamps. It keeps its
// own ring of frame times, running sum and fill count, and queues one
// expected rate per accepted timestamp. Each result transfer is checked
// against the oldest queued rate, one field at a time.
// ----------------------------------------------------------------------------
module wfrm_checker
  import wfrm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_ready,
  input  logic [TS_W-1:0]  in_frame_timestamp,
  input  logic             out_valid,
  input  logic             out_ready,
  input  logic [FPS_W-1:0] out_fps_value,
  input  logic             out_saturated,
  input  logic             cfg_we,
  input  logic [TS_W-1:0]  cfg_wdata,
  output int               mismatches,
  output int               rates_pending,
  output int               rates_checked,
  output int               sat_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [FPS_W-1:0] fps;
    logic             sat;
  } rate_t;

  // Model state of the meter
  logic [TS_W-1:0] frame_time_ring [WINDOW];
  logic [TS_W-1:0] prev_frame_end;
  int unsigned     ring_slot;
  int unsigned     frames_held;
  logic [63:0]     time_total;
  rate_t           rate_queue [$];

  // Fold one frame end into the window and work out the rate it yields
  function automatic rate_t next_rate(input logic [TS_W-1:0] now);
    logic [TS_W-1:0] frame_ms;
    logic [63:0]     numer;
    logic [63:0]     quot;
    rate_t           r;
    frame_ms       = now - prev_frame_end;  // wraps modulo 2^32
    prev_frame_end = now;
    // full window: oldest time leaves the sum first
    if (frames_held >= WINDOW) begin
      time_total = time_total - 64'(frame_time_ring[ring_slot]);
    end else begin
      frames_held++;
    end
    frame_time_ring[ring_slot] = frame_ms;
    time_total = time_total + 64'(frame_ms);
    ring_slot  = (ring_slot + 1 >= WINDOW) ? 0 : ring_slot + 1;
    if (time_total == 0) begin
      r = '{fps: '1, sat: 1'b1};
    end else begin
      numer = (64'(MS_PER_SEC) * 64'(frames_held)) << Q_FRAC;
      quot  = numer / time_total;
      if (quot > 64'({FPS_W{1'b1}})) begin
        r = '{fps: '1, sat: 1'b1};
      end else begin
        r = '{fps: quot[FPS_W-1:0], sat: 1'b0};
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin : watch
    rate_t due;
    if (!rst_n) begin
      prev_frame_end = '0;
      ring_slot      = 0;
      frames_held    = 0;
      time_total     = '0;
      rate_queue.delete();
    end else begin
      if (cfg_we) begin
        prev_frame_end = cfg_wdata;
      end
      // result side first, so a transfer never meets its own expectation
      if (out_valid && out_ready) begin
        if (rate_queue.size() == 0) begin
          $error("result with no timestamp pending: fps_value=%h saturated=%b",
                 out_fps_value, out_saturated);
          mismatches++;
        end else begin
          due = rate_queue.pop_front();
          rates_checked++;
          if (due.sat) sat_seen++;
          if (out_fps_value !== due.fps) begin
            $error("fps_value mismatch: expected %h, actual %h", due.fps, out_fps_value);
            mismatches++;
          end
          if (out_saturated !== due.sat) begin
            $error("saturated mismatch: expected %b, actual %b", due.sat, out_saturated);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) begin
        rate_queue.push_back(next_rate(in_frame_timestamp));
      end
    end
    rates_pending = rate_queue.size();
  end

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the windowed frame-rate meter.
// ----------------------------------------------------------------------------
// Drives frame-end timestamps and start-time loads into the meter and lets
// the checker predict and compare every rate. A directed opening covers
// zero-sum saturation, timestamp wrap, extreme deltas and window eviction;
// random phases follow with sender gaps, receiver stalls and a long output
// hold-off that backs the meter up into its input.
// ----------------------------------------------------------------------------
module tb_top
  import wfrm_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 4000;  // cycles without any transfer
  localparam int HOLD_CYCLES    = 400;   // long output hold-off
  localparam int TAIL_CYCLES    = 80;    // longer than one item's latency

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  logic [TS_W-1:0]  in_frame_timestamp;
  logic             out_valid;
  logic             out_ready;
  logic [FPS_W-1:0] out_fps_value;
  logic             out_saturated;
  logic             cfg_we;
  logic [TS_W-1:0]  cfg_wdata;

  int mismatches;
  int rates_pending;
  int rates_checked;
  int sat_seen;

  int              tx_idle_pct;
  int              rx_stall_pct;
  bit              rx_hold_req;
  logic [TS_W-1:0] last_sent;
  int              freeze_left;
  int              items_sent;
  int              start_loads;
  int              quiet_cycles;

  windowed_frame_rate_meter_top DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_frame_timestamp (in_frame_timestamp),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_fps_value      (out_fps_value),
    .out_saturated      (out_saturated),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata)
  );

  wfrm_checker rate_check (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_frame_timestamp (in_frame_timestamp),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_fps_value      (out_fps_value),
    .out_saturated      (out_saturated),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .mismatches         (mismatches),
    .rates_pending      (rates_pending),
    .rates_checked      (rates_checked),
    .sat_seen           (sat_seen)
  );

  // Clock
  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Watchdog: no transfer on either channel for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: %0d cycles without a transfer", quiet_cycles);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Receiver: random stalls, plus a long hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_ready <= (rst_n && $urandom_range(99) >= rx_stall_pct);
    end
  end

  // Offer one timestamp; returns at the edge where it transfers
  task automatic send_frame(input logic [TS_W-1:0] ts);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid           <= 1'b1;
    in_frame_timestamp <= ts;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    last_sent = ts;
    items_sent++;
  endtask

  // Let every rate come out, then load a new start time
  task automatic load_start(input logic [TS_W-1:0] value);
    @(negedge clk);
    in_valid <= 1'b0;
    while (rates_pending != 0) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    last_sent = value;
    start_loads++;
  endtask

  // Mostly steady frame times; freezes, long gaps, jumps and backward steps
  function automatic logic [TS_W-1:0] pick_timestamp();
    int kind;
    if (freeze_left > 0) begin
      freeze_left--;
      return last_sent;
    end
    kind = $urandom_range(99);
    if (kind < 60) return last_sent + $urandom_range(50, 1);
    if (kind < 70) begin
      freeze_left = $urandom_range(20, 1);
      return last_sent;
    end
    if (kind < 82) return last_sent + $urandom_range(70000, 51);
    if (kind < 92) return $urandom();
    return last_sent - $urandom_range(255, 1);
  endfunction

  task automatic run_frames(input int count);
    repeat (count) send_frame(pick_timestamp());
  endtask

  initial begin
    rst_n              = 1'b0;
    in_valid           = 1'b0;
    in_frame_timestamp = '0;
    cfg_we             = 1'b0;
    cfg_wdata          = '0;
    tx_idle_pct        = 0;
    rx_stall_pct       = 0;
    rx_hold_req        = 1'b0;
    last_sent          = '0;
    freeze_left        = 0;
    items_sent         = 0;
    start_loads        = 0;
    quiet_cycles       = 0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: zero-sum saturation, wrap, extreme deltas, window eviction
    load_start(32'hFFFF_FFF0);
    repeat (3) send_frame(32'hFFFF_FFF0);
    send_frame(32'hFFFF_FFF1);
    send_frame(32'h0000_0003);
    send_frame(32'hFFFF_FFFF);
    send_frame(32'hFFFF_FFFF);
    for (int k = 0; k < 12; k++) send_frame(last_sent + 32'd16);
    load_start(32'h0000_0000);
    send_frame(32'h8000_0000);
    send_frame(32'h0000_0000);
    load_start(32'hFFFF_FFFF);
    send_frame(32'h0000_0000);

    // Random, no idling, with a long output hold-off up front
    load_start($urandom());
    rx_hold_req = 1'b1;
    run_frames(180);

    // Sender mostly idle
    tx_idle_pct = 87;
    load_start(32'h0000_0000);
    run_frames(170);

    // Receiver mostly stalled
    tx_idle_pct  = 0;
    rx_stall_pct = 87;
    load_start(32'hFFFF_FFFF);
    run_frames(170);

    // Both sides idling now and then
    tx_idle_pct  = 33;
    rx_stall_pct = 33;
    load_start($urandom());
    run_frames(180);

    // Drain and let any stray result show up
    @(negedge clk);
    in_valid <= 1'b0;
    while (rates_pending != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Sent %0d timestamps across %0d start-time loads and four idle/stall mixes.",
             items_sent, start_loads);
    $display("Checked %0d rates, %0d of them saturated.", rates_checked, sat_seen);
    if (mismatches == 0 && rates_pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/wfrm_pkg.sv
hdl/wfrm_accum.sv
hdl/wfrm_div.sv
hdl/windowed_frame_rate_meter_top.sv
hdl/wfrm_checker.sv
tb/wfrm_checker.sv
tb/tb_top.sv
